[src/ppe_pkg.sv]
// ----------------------------------------------------------------------------
// ppe_pkg
// shared constants, codes and the job record for the palette expander
// ----------------------------------------------------------------------------
package ppe_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int PAL_DEPTH   = 256;
    localparam int PAL_IDX_W   = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // pixel modes
    localparam logic [1:0] MODE_1BPP  = 2'd0;
    localparam logic [1:0] MODE_4BPP  = 2'd1;
    localparam logic [1:0] MODE_8BPP  = 2'd2;
    localparam logic [1:0] MODE_24BPP = 2'd3;

    // input item kinds
    localparam logic [1:0] KIND_PALETTE = 2'd0;
    localparam logic [1:0] KIND_PIXEL   = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MODE      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PAL_COUNT = 2'd3;

    // one unit of work for the back end: a palette write or a run of pixels
    typedef struct packed {
        logic                 is_pal;
        logic [1:0]           mode;
        logic [7:0]           data;
        logic [9:0]           col;
        logic [15:0]          row;
        logic [3:0]           count;
        logic                 err;
        logic [23:0]          color;
    } ppe_job_t;

endpackage

[src/ppe_in_if.sv]
// ----------------------------------------------------------------------------
// ppe_in_if
// input channel: palette writes, pattern bytes and restarts
// ----------------------------------------------------------------------------
interface ppe_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  palette_slot;
    logic [23:0] palette_rgb;
    logic [7:0]  data_byte;

    modport source (output valid, output kind, output palette_slot,
                    output palette_rgb, output data_byte, input ready);
    modport sink (input valid, input kind, input palette_slot,
                  input palette_rgb, input data_byte, output ready);
endinterface

[src/ppe_out_if.sv]
// ----------------------------------------------------------------------------
// ppe_out_if
// output channel: one argb pixel per transaction
// ----------------------------------------------------------------------------
interface ppe_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_argb;
    logic [9:0]  pixel_column;
    logic [15:0] pixel_row;
    logic        palette_error;
    logic        run_last;

    modport source (output valid, output pixel_argb, output pixel_column,
                    output pixel_row, output palette_error, output run_last,
                    input ready);
    modport sink (input valid, input pixel_argb, input pixel_column,
                  input pixel_row, input palette_error, input run_last,
                  output ready);
endinterface

[src/packed_pixel_palette_expander_unit.sv]
// an accepted byte's pixels pass the job queue, lookup stage and output register
// throughput: the back end emits one pixel per cycle while the output is not stalled;
// a 1bpp byte yields up to 8 pixels, a 4bpp byte up to 2, an 8bpp byte at most 1
// the front end takes one item per cycle while the 4-entry job queue has room
// reset: asynchronous active low, clears config and position; palette is not cleared
// ----------------------------------------------------------------------------
// packed_pixel_palette_expander_unit
// unpacks 1/4/8 bpp palette pixels and 24 bpp bgr pixels into argb
// ----------------------------------------------------------------------------
module packed_pixel_palette_expander_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ppe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppe_pkg::CFG_DATA_W-1:0]  cfg_data,
    ppe_in_if.sink                          items,
    ppe_out_if.source                       pixels
);
    import ppe_pkg::*;

    ppe_job_t push_job;
    ppe_job_t head_job;
    logic     push;
    logic     full;
    logic     pop;
    logic     head_valid;

    ppe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items),
        .push      (push),
        .job       (push_job),
        .full      (full)
    );

    ppe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (push_job),
        .full      (full),
        .pop       (pop),
        .dout      (head_job),
        .not_empty (head_valid)
    );

    ppe_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head_job),
        .head_valid (head_valid),
        .pop        (pop),
        .pixels     (pixels)
    );

endmodule

[src/ppe_queue.sv]
// ----------------------------------------------------------------------------
// ppe_queue
// small job fifo between the front end and the back end
// ----------------------------------------------------------------------------
module ppe_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ppe_pkg::ppe_job_t din,
    output logic             full,
    input  logic             pop,
    output ppe_pkg::ppe_job_t dout,
    output logic             not_empty
);
    import ppe_pkg::*;

    ppe_job_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    assign full      = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign dout      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("job popped from an empty queue");

    a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> fill_reg == $past(fill_reg) + (QPTR_W+1)'(1))
        else $error("fill count lost a push");
`endif

endmodule

[src/ppe_front.sv]
// ----------------------------------------------------------------------------
// ppe_front
// config registers, row/column bookkeeping and job building per input byte
// ----------------------------------------------------------------------------
module ppe_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ppe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppe_pkg::CFG_DATA_W-1:0]  cfg_data,
    ppe_in_if.sink                          items,
    output logic                            push,
    output ppe_pkg::ppe_job_t               job,
    input  logic                            full
);
    import ppe_pkg::*;

    logic [10:0] width_reg;
    logic [15:0] height_reg;
    logic [1:0]  mode_reg;
    logic [8:0]  pal_count_reg;

    logic [11:0] byte_in_row_reg, byte_in_row_next;
    logic [10:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [15:0] partial_reg, partial_next;
    logic [1:0]  phase_reg, phase_next;

    logic        accept;
    logic [10:0] eff_w;
    logic [14:0] row_bits;
    logic [15:0] bits_round;
    logic [12:0] stride;
    logic        stride_zero;
    logic        row_end;
    logic [16:0] row_inc;
    logic        pal_ok;
    logic [10:0] avail;
    logic [12:0] w3;
    logic [3:0]  count;
    logic        err;
    logic        emit;

    assign items.ready = !full;
    assign accept      = items.valid && items.ready;

    assign eff_w = (width_reg > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : width_reg;

    always_comb
    begin
        unique case (mode_reg)
            MODE_1BPP: row_bits = {4'b0, eff_w};
            MODE_4BPP: row_bits = {2'b0, eff_w, 2'b0};
            MODE_8BPP: row_bits = {1'b0, eff_w, 3'b0};
            default:   row_bits = {eff_w, 4'b0} + {1'b0, eff_w, 3'b0};
        endcase
    end

    // stride in bytes, rounded up to a whole 16-bit word
    assign bits_round  = {1'b0, row_bits} + 16'd15;
    assign stride      = {bits_round[15:4], 1'b0};
    assign stride_zero = (bits_round[15:4] == '0);
    assign row_end     = ({1'b0, byte_in_row_reg} + 13'd1) >= stride;
    assign row_inc     = {1'b0, row_reg} + 17'd1;
    assign w3          = {1'b0, eff_w, 1'b0} + {2'b0, eff_w};
    assign avail       = (col_reg < eff_w) ? (eff_w - col_reg) : 11'd0;

    always_comb
    begin
        unique case (mode_reg)
            MODE_1BPP: pal_ok = (pal_count_reg >= 9'd2);
            MODE_4BPP: pal_ok = (pal_count_reg >= 9'd16);
            MODE_8BPP: pal_ok = (pal_count_reg >= 9'd256);
            default:   pal_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        byte_in_row_next = byte_in_row_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        partial_next     = partial_reg;
        phase_next       = phase_reg;
        count            = 4'd0;
        err              = 1'b0;
        emit             = 1'b0;

        if (accept)
        begin
            unique case (items.kind)
                KIND_PALETTE:
                begin
                    emit = 1'b1;
                end
                KIND_RESTART:
                begin
                    byte_in_row_next = '0;
                    col_next         = '0;
                    row_next         = '0;
                    partial_next     = '0;
                    phase_next       = '0;
                end
                KIND_PIXEL:
                begin
                    if (!stride_zero)
                    begin
                        if (!pal_ok)
                        begin
                            count = 4'd1;
                            err   = 1'b1;
                        end
                        else
                        begin
                            unique case (mode_reg)
                                MODE_1BPP:
                                    count = (avail >= 11'd8) ? 4'd8 : avail[3:0];
                                MODE_4BPP:
                                    count = (avail >= 11'd2) ? 4'd2 : avail[3:0];
                                MODE_8BPP:
                                    count = (avail >= 11'd1) ? 4'd1 : 4'd0;
                                default:
                                begin
                                    if ({1'b0, byte_in_row_reg} < w3)
                                    begin
                                        if (phase_reg == 2'd0)
                                        begin
                                            partial_next = {8'b0, items.data_byte};
                                            phase_next   = 2'd1;
                                        end
                                        else if (phase_reg == 2'd1)
                                        begin
                                            partial_next = {items.data_byte,
                                                            partial_reg[7:0]};
                                            phase_next   = 2'd2;
                                        end
                                        else
                                        begin
                                            count        = (avail != '0) ? 4'd1 : 4'd0;
                                            partial_next = '0;
                                            phase_next   = 2'd0;
                                        end
                                    end
                                end
                            endcase
                            col_next = col_reg + {7'b0, count};
                        end

                        if (row_end)
                        begin
                            byte_in_row_next = '0;
                            col_next         = '0;
                            partial_next     = '0;
                            phase_next       = '0;
                            row_next = (row_inc >= {1'b0, height_reg}) ? 16'd0
                                                                       : row_inc[15:0];
                        end
                        else
                        begin
                            byte_in_row_next = byte_in_row_reg + 12'd1;
                        end
                        emit = (count != 4'd0);
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
    end

    assign push = emit;

    always_comb
    begin
        job.is_pal = (items.kind == KIND_PALETTE);
        job.mode   = mode_reg;
        job.data   = job.is_pal ? items.palette_slot : items.data_byte;
        job.col    = col_reg[9:0];
        job.row    = row_reg;
        job.count  = job.is_pal ? 4'd0 : count;
        job.err    = err;
        job.color  = job.is_pal ? items.palette_rgb : {items.data_byte, partial_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= '0;
            height_reg    <= '0;
            mode_reg      <= MODE_24BPP;
            pal_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:     width_reg     <= cfg_data[10:0];
                REG_HEIGHT:    height_reg    <= cfg_data[15:0];
                REG_MODE:      mode_reg      <= cfg_data[1:0];
                REG_PAL_COUNT: pal_count_reg <= cfg_data[8:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_row_reg <= '0;
            col_reg         <= '0;
            row_reg         <= '0;
            partial_reg     <= '0;
            phase_reg       <= '0;
        end
        else
        begin
            byte_in_row_reg <= byte_in_row_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            partial_reg     <= partial_next;
            phase_reg       <= phase_next;
        end
    end

endmodule

[src/ppe_back.sv]
// ----------------------------------------------------------------------------
// ppe_back
// palette memory, sequencer, output register: one pixel per cycle unless stalled
// ----------------------------------------------------------------------------
module ppe_back (
    input  logic              clk,
    input  logic              rst_n,
    input  ppe_pkg::ppe_job_t head,
    input  logic              head_valid,
    output logic              pop,
    ppe_out_if.source         pixels
);
    import ppe_pkg::*;

    logic [23:0]          pal_mem_reg [PAL_DEPTH];
    logic [23:0]          pal_rd_reg;
    logic [2:0]           seq_k_reg;

    logic                 s1_valid_reg;
    logic                 s1_use_pal_reg;
    logic                 s1_err_reg;
    logic                 s1_last_reg;
    logic [23:0]          s1_color_reg;
    logic [9:0]           s1_col_reg;
    logic [15:0]          s1_row_reg;

    logic                 out_valid_reg;
    logic [31:0]          out_argb_reg;
    logic [9:0]           out_col_reg;
    logic [15:0]          out_row_reg;
    logic                 out_err_reg;
    logic                 out_last_reg;

    logic                 out_free;
    logic                 s1_free;
    logic                 issue;
    logic                 pal_wr;
    logic                 last_pix;
    logic [PAL_IDX_W-1:0] rd_idx;

    assign out_free = !out_valid_reg || pixels.ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign pal_wr   = head_valid && head.is_pal;
    assign issue    = head_valid && !head.is_pal && s1_free;
    assign last_pix = (({1'b0, seq_k_reg} + 4'd1) == head.count);
    assign pop      = pal_wr || (issue && last_pix);

    // pixels leave the byte msb first
    always_comb
    begin
        unique case (head.mode)
            MODE_1BPP: rd_idx = {7'b0, head.data[3'd7 - seq_k_reg]};
            MODE_4BPP: rd_idx = (seq_k_reg == 3'd0) ? {4'b0, head.data[7:4]}
                                                    : {4'b0, head.data[3:0]};
            MODE_8BPP: rd_idx = head.data;
            default:   rd_idx = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pal_wr)
        begin
            pal_mem_reg[head.data] <= head.color;
        end
        if (issue)
        begin
            pal_rd_reg <= pal_mem_reg[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_use_pal_reg <= (head.mode != MODE_24BPP);
            s1_err_reg     <= head.err;
            s1_last_reg    <= last_pix;
            s1_color_reg   <= head.color;
            s1_col_reg     <= head.col + {7'b0, seq_k_reg};
            s1_row_reg     <= head.row;
        end
        if (out_free && s1_valid_reg)
        begin
            out_argb_reg <= s1_err_reg ? 32'd0
                          : {8'hFF, s1_use_pal_reg ? pal_rd_reg : s1_color_reg};
            out_col_reg  <= s1_col_reg;
            out_row_reg  <= s1_row_reg;
            out_err_reg  <= s1_err_reg;
            out_last_reg <= s1_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_k_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                seq_k_reg <= last_pix ? 3'd0 : seq_k_reg + 3'd1;
            end
            if (issue)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    assign pixels.valid         = out_valid_reg;
    assign pixels.pixel_argb    = out_argb_reg;
    assign pixels.pixel_column  = out_col_reg;
    assign pixels.pixel_row     = out_row_reg;
    assign pixels.palette_error = out_err_reg;
    assign pixels.run_last      = out_last_reg;

`ifndef SYNTHESIS
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_col_reg)))
        else $error("lookup stage dropped a pixel under stall");

    a_job_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && !head.is_pal) |->
            (head.count != 4'd0 && ({1'b0, seq_k_reg} < head.count)))
        else $error("pixel index outside the job");

    a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !head.is_pal) |-> last_pix)
        else $error("pixel job retired early");

    a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
        (pixels.valid && pixels.palette_error) |->
            (pixels.pixel_argb == 32'd0 && pixels.run_last))
        else $error("error result carries a color");
`endif

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives palette writes, pattern bytes and restarts through the packed pixel
// palette expander. A local predictor works out the expected argb pixels for
// every item. Each output transaction is checked in order against them.
// ----------------------------------------------------------------------------
module testbench;
    import ppe_pkg::*;

    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int MAX_GAP      = 4;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 40;
    localparam int HOLD_CYCLES  = 200;

    typedef struct packed {
        logic [31:0] argb;
        logic [9:0]  column;
        logic [15:0] row;
        logic        error;
        logic        last;
    } pixel_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    ppe_in_if  items_if ();
    ppe_out_if pixels_if ();

    packed_pixel_palette_expander_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .items     (items_if),
        .pixels    (pixels_if)
    );

    pixel_t expected_pixels [$];
    int     mismatches   = 0;
    int     cycle_count  = 0;
    bit     src_idle     = 1'b1;
    bit     sink_idle    = 1'b1;
    int     hold_request = 0;

    // shadow of the format registers and the unpacking position
    logic [10:0] fmt_width;
    logic [15:0] fmt_height;
    logic [1:0]  fmt_mode;
    logic [8:0]  fmt_pal_count;
    logic [23:0] pal_shadow [PAL_DEPTH];
    logic [11:0] pos_byte;
    logic [10:0] pos_col;
    logic [15:0] pos_row;
    logic [15:0] bgr_partial;
    logic [1:0]  bgr_phase;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("ERROR: %s", msg);
    endtask

    task automatic clear_position();
        pos_byte    = '0;
        pos_col     = '0;
        pos_row     = '0;
        bgr_partial = '0;
        bgr_phase   = '0;
    endtask

    function automatic pixel_t make_pixel(input logic [31:0] argb, input logic err);
        pixel_t px;
        px.argb   = argb;
        px.column = pos_col[9:0];
        px.row    = pos_row;
        px.error  = err;
        px.last   = 1'b0;
        return px;
    endfunction

    // expected pixels for one accepted item, in emission order
    task automatic unpack_item(input logic [1:0] kind, input logic [7:0] slot,
                               input logic [23:0] rgb, input logic [7:0] data);
        pixel_t     run [8];
        int         n;
        int         w;
        int         bpp;
        int         need;
        int         stride;
        logic [7:0] idx;
        n = 0;
        case (kind)
            KIND_PALETTE: pal_shadow[slot] = rgb;
            KIND_RESTART: clear_position();
            KIND_PIXEL:
            begin
                w = (int'(fmt_width) > MAX_WIDTH) ? MAX_WIDTH : int'(fmt_width);
                case (fmt_mode)
                    MODE_1BPP:
                    begin
                        bpp  = 1;
                        need = 2;
                    end
                    MODE_4BPP:
                    begin
                        bpp  = 4;
                        need = 16;
                    end
                    MODE_8BPP:
                    begin
                        bpp  = 8;
                        need = 256;
                    end
                    default:
                    begin
                        bpp  = 24;
                        need = 0;
                    end
                endcase
                stride = ((w * bpp + 15) / 16) * 2;
                if (stride != 0)
                begin
                    if (fmt_mode != MODE_24BPP && int'(fmt_pal_count) < need)
                    begin
                        run[n] = make_pixel(32'd0, 1'b1);
                        n++;
                    end
                    else if (fmt_mode == MODE_1BPP)
                    begin
                        for (int i = 7; i >= 0; i--)
                        begin
                            if (int'(pos_col) < w)
                            begin
                                idx = {7'd0, data[i]};
                                run[n] = make_pixel({8'hFF, pal_shadow[idx]}, 1'b0);
                                n++;
                                pos_col++;
                            end
                        end
                    end
                    else if (fmt_mode == MODE_4BPP)
                    begin
                        // high nibble goes out first
                        for (int i = 1; i >= 0; i--)
                        begin
                            if (int'(pos_col) < w)
                            begin
                                idx = (data >> (4 * i)) & 8'h0F;
                                run[n] = make_pixel({8'hFF, pal_shadow[idx]}, 1'b0);
                                n++;
                                pos_col++;
                            end
                        end
                    end
                    else if (fmt_mode == MODE_8BPP)
                    begin
                        if (int'(pos_col) < w)
                        begin
                            run[n] = make_pixel({8'hFF, pal_shadow[data]}, 1'b0);
                            n++;
                            pos_col++;
                        end
                    end
                    else if (int'(pos_byte) < w * 3)
                    begin
                        // bytes arrive blue, green, red
                        if (bgr_phase == 2'd0)
                        begin
                            bgr_partial = {8'd0, data};
                            bgr_phase   = 2'd1;
                        end
                        else if (bgr_phase == 2'd1)
                        begin
                            bgr_partial = {data, bgr_partial[7:0]};
                            bgr_phase   = 2'd2;
                        end
                        else
                        begin
                            if (int'(pos_col) < w)
                            begin
                                run[n] = make_pixel({8'hFF, data, bgr_partial}, 1'b0);
                                n++;
                                pos_col++;
                            end
                            bgr_phase   = 2'd0;
                            bgr_partial = '0;
                        end
                    end

                    if (int'(pos_byte) + 1 >= stride)
                    begin
                        pos_byte    = '0;
                        pos_col     = '0;
                        bgr_partial = '0;
                        bgr_phase   = '0;
                        if (int'(pos_row) + 1 >= int'(fmt_height))
                            pos_row = '0;
                        else
                            pos_row = pos_row + 16'd1;
                    end
                    else
                    begin
                        pos_byte = pos_byte + 12'd1;
                    end
                end
            end
            default: ;
        endcase
        if (n > 0)
            run[n-1].last = 1'b1;
        for (int i = 0; i < n; i++)
            expected_pixels.push_back(run[i]);
    endtask

    task automatic send_item(input logic [1:0] kind, input logic [7:0] slot,
                             input logic [23:0] rgb, input logic [7:0] data);
        int gap;
        gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0)
        begin
            items_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        items_if.valid        <= 1'b1;
        items_if.kind         <= kind;
        items_if.palette_slot <= slot;
        items_if.palette_rgb  <= rgb;
        items_if.data_byte    <= data;
        @(posedge clk);
        while (!items_if.ready)
            @(posedge clk);
        unpack_item(kind, slot, rgb, data);
    endtask

    task automatic send_byte(input logic [7:0] data);
        send_item(KIND_PIXEL, 8'($urandom()), 24'($urandom()), data);
    endtask

    task automatic send_palette(input logic [7:0] slot, input logic [23:0] rgb);
        send_item(KIND_PALETTE, slot, rgb, 8'($urandom()));
    endtask

    task automatic send_restart();
        send_item(KIND_RESTART, 8'($urandom()), 24'($urandom()), 8'($urandom()));
    endtask

    task automatic send_unused();
        send_item(KIND_UNUSED, 8'($urandom()), 24'($urandom()), 8'($urandom()));
    endtask

    // wait until every expected pixel is out and the pipeline has settled
    task automatic drain();
        items_if.valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        case (index)
            REG_WIDTH:     fmt_width     = value[10:0];
            REG_HEIGHT:    fmt_height    = value[15:0];
            REG_MODE:      fmt_mode      = value[1:0];
            REG_PAL_COUNT: fmt_pal_count = value[8:0];
            default: ;
        endcase
    endtask

    task automatic set_format(input int width, input int height, input logic [1:0] mode,
                              input int count);
        drain();
        write_reg(REG_WIDTH, CFG_DATA_W'(width));
        write_reg(REG_HEIGHT, CFG_DATA_W'(height));
        write_reg(REG_MODE, CFG_DATA_W'(mode));
        write_reg(REG_PAL_COUNT, CFG_DATA_W'(count));
        cfg_we <= 1'b0;
    endtask

    task automatic check_pixel();
        pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            report($sformatf("unexpected pixel argb=%h col=%0d row=%0d",
                             pixels_if.pixel_argb, pixels_if.pixel_column,
                             pixels_if.pixel_row));
            return;
        end
        want = expected_pixels.pop_front();
        if (pixels_if.pixel_argb !== want.argb)
            report($sformatf("argb %h, expected %h (col %0d row %0d)",
                             pixels_if.pixel_argb, want.argb, want.column, want.row));
        if (pixels_if.pixel_column !== want.column)
            report($sformatf("column %0d, expected %0d",
                             pixels_if.pixel_column, want.column));
        if (pixels_if.pixel_row !== want.row)
            report($sformatf("row %0d, expected %0d", pixels_if.pixel_row, want.row));
        if (pixels_if.palette_error !== want.error)
            report($sformatf("palette_error %b, expected %b (col %0d row %0d)",
                             pixels_if.palette_error, want.error, want.column, want.row));
        if (pixels_if.run_last !== want.last)
            report($sformatf("run_last %b, expected %b (col %0d row %0d)",
                             pixels_if.run_last, want.last, want.column, want.row));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pixels_if.valid && pixels_if.ready)
            check_pixel();
    end

    // output side: random gap after each transaction, plus long holds on request
    initial
    begin : pixel_sink
        int wait_left;
        int hold_left;
        wait_left = 0;
        hold_left = 0;
        pixels_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                continue;
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pixels_if.ready <= 1'b0;
            end
            else if (pixels_if.valid && pixels_if.ready)
            begin
                wait_left = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
                if (wait_left > 0)
                    pixels_if.ready <= 1'b0;
            end
            else if (!pixels_if.ready)
            begin
                if (wait_left > 0)
                    wait_left--;
                if (wait_left == 0)
                    pixels_if.ready <= 1'b1;
            end
        end
    end

    // after reset the width is zero, so pattern bytes produce nothing
    task automatic test_reset_defaults();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_unused();
    endtask

    // fill every slot so that no lookup ever hits an unwritten entry
    task automatic load_palette();
        for (int slot = 0; slot < PAL_DEPTH; slot++)
        begin
            if (slot == 0)
                send_palette(8'(slot), 24'h000000);
            else if (slot == PAL_DEPTH - 1)
                send_palette(8'(slot), 24'hFFFFFF);
            else
                send_palette(8'(slot), 24'($urandom()));
        end
    endtask

    task automatic test_pixel_modes();
        // width 5 at 1bpp: one data byte and one padding byte per row
        set_format(5, 2, MODE_1BPP, 2);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'hA5);
        set_format(3, 1, MODE_4BPP, 16);
        send_byte(8'h0F);
        send_byte(8'hF0);
        set_format(2, 3, MODE_8BPP, 256);
        send_byte(8'h00);
        send_byte(8'hFF);
        // one bgr pixel then one padding byte
        set_format(1, 2, MODE_24BPP, 0);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_special_cases();
        // palette smaller than the mode needs
        set_format(4, 2, MODE_8BPP, 255);
        send_byte(8'h12);
        set_format(4, 2, MODE_1BPP, 1);
        send_byte(8'hFF);
        set_format(4, 2, MODE_4BPP, 15);
        send_byte(8'h34);
        // restart in the middle of a bgr triple
        set_format(4, 4, MODE_24BPP, 256);
        send_byte(8'hAA);
        send_restart();
        send_byte(8'h10);
        send_byte(8'h20);
        send_byte(8'h30);
        // zero height keeps every row at zero
        set_format(1, 0, MODE_8BPP, 256);
        send_byte(8'h80);
        send_byte(8'h7F);
        send_byte(8'h01);
        // width over the maximum is clamped
        set_format(2047, 65535, MODE_1BPP, 256);
        send_byte(8'h96);
        send_byte(8'h69);
        // width shrinks mid-row: the rest of the row ends at once
        set_format(8, 4, MODE_8BPP, 256);
        send_byte(8'h05);
        send_unused();
        send_byte(8'h06);
        send_byte(8'h07);
        set_format(2, 4, MODE_8BPP, 256);
        send_byte(8'h08);
        send_byte(8'h09);
    endtask

    // output held off while the input keeps offering bytes back to back
    task automatic test_backpressure();
        set_format(16, 8, MODE_1BPP, 256);
        src_idle     = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 30; i++)
            send_byte(8'($urandom()));
        src_idle = 1'b1;
    endtask

    task automatic test_random();
        int width;
        int height;
        int count;
        int pick;
        for (int phase = 0; phase < 8; phase++)
        begin
            case ($urandom_range(0, 9))
                0:       width = MAX_WIDTH;
                1:       width = $urandom_range(0, 2047);
                default: width = $urandom_range(1, 24);
            endcase
            case ($urandom_range(0, 5))
                0:       height = 0;
                1:       height = 65535;
                2:       height = $urandom_range(0, 65535);
                default: height = $urandom_range(1, 6);
            endcase
            count     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 256) : 256;
            src_idle  = ($urandom_range(0, 3) != 0);
            sink_idle = ($urandom_range(0, 3) != 0);
            set_format(width, height, 2'($urandom_range(0, 3)), count);
            for (int k = 0; k < 5; k++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 82)
                    send_byte(8'($urandom()));
                else if (pick < 90)
                    send_palette(8'($urandom()), 24'($urandom()));
                else if (pick < 95)
                    send_restart();
                else
                begin
                    send_unused();
                    send_byte(8'($urandom()));
                end
            end
        end
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial
    begin
        items_if.valid        <= 1'b0;
        items_if.kind         <= KIND_PALETTE;
        items_if.palette_slot <= '0;
        items_if.palette_rgb  <= '0;
        items_if.data_byte    <= '0;
        cfg_we                <= 1'b0;
        cfg_index             <= REG_WIDTH;
        cfg_data              <= '0;
        fmt_width             = '0;
        fmt_height            = '0;
        fmt_mode              = MODE_24BPP;
        fmt_pal_count         = '0;
        clear_position();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        load_palette();
        test_pixel_modes();
        test_special_cases();
        test_backpressure();
        test_random();
        drain();

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
